[rtl/ppmfg_pkg.sv]
// Shared types and constants of the pulse-position frame generator.
// Used by every rtl module but ppmfg_ram; depends on nothing else.
`timescale 1ns / 1ps

package ppmfg_pkg;

	localparam int SLOT_W  = 5;
	localparam int VALUE_W = 16;
	localparam int WORD_W  = 32;

	localparam logic [VALUE_W-1:0] TABLE_RESET = 16'd3000;

	typedef enum logic [1:0] {
		ACT_EDGE      = 2'd0,
		ACT_WRITE     = 2'd1,
		ACT_FLAG      = 2'd2,
		ACT_SET_COUNT = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		REG_CHANNEL_COUNT = 3'd0,
		REG_FRAME_PERIOD  = 3'd1,
		REG_MIN_VALUE     = 3'd2,
		REG_MAX_VALUE     = 3'd3,
		REG_MIN_GAP       = 3'd4,
		REG_SPACER_WIDTH  = 3'd5,
		REG_INVERTED      = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [SLOT_W-1:0]  channel_count;
		logic [VALUE_W-1:0] frame_period;
		logic [VALUE_W-1:0] min_value;
		logic [VALUE_W-1:0] max_value;
		logic [VALUE_W-1:0] min_gap;
		logic [VALUE_W-1:0] spacer_width;
		logic               inverted;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		channel_count: 5'd8,
		frame_period:  16'd40000,
		min_value:     16'd1800,
		max_value:     16'd4200,
		min_gap:       16'd6000,
		spacer_width:  16'd800,
		inverted:      1'b0
	};

endpackage

[rtl/ppm_frame_generator.sv]
// Pulse-position frame generator, top level.
// Depends on ppmfg_pkg, ppmfg_cfg, ppmfg_table and ppmfg_ram.
//
// Usage:
//   s_* carries commands: s_tuser selects edge event, channel write, flag read
//   or frame count load; s_tdata holds slot, channel value and frame count.
//   m_* returns exactly one result per command: the interval to the next edge,
//   pin level, next slot, frame counter, elapsed time, flag and stored value.
//   cfg_* writes the seven settings (index 0..6); write only while idle.
// Path: a command passes the input stage, where the channel table is read,
//   then the output register, which holds its result until m_tready takes it.
// Throughput: one command per cycle while m_tready stays high; both table
//   read ports are read for each item.
// Reset: settings return to their defaults, phase, slot, elapsed time, frame
//   counter and done flags clear, and every table entry reads 3000.
// Stall: while m_tready is low the output register holds its result; the
//   input stage still takes one more command, then s_tready drops until the
//   output is taken.
`timescale 1ns / 1ps

module ppm_frame_generator #(
	parameter int MAX_CHANNELS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// [3:0] slot, [19:4] new_value, [51:20] new_frame_count, [55:52] zero
	input  logic [55:0]  s_tdata,
	// [1:0] action
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// [15:0] interval, [16] pin_level, [21:17] next_slot, [53:22] frames_sent,
	// [85:54] elapsed, [86] flag, [102:87] stored_value, [103] zero
	output logic [103:0] m_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [15:0]  cfg_data
);

	localparam int SW = ppmfg_pkg::SLOT_W;
	localparam int VW = ppmfg_pkg::VALUE_W;
	localparam int WW = ppmfg_pkg::WORD_W;
	localparam int IW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int FN = MAX_CHANNELS + 1;

	ppmfg_pkg::cfg_t cfg;

	// Settings-derived values.
	logic [SW-1:0] count;
	logic [SW-1:0] slot_top;
	logic [SW-1:0] slot_in;
	logic [SW-1:0] slot_c;

	// Handshake.
	logic in_fire;
	logic out_adv;
	logic s1_fire;

	// Input stage.
	logic                s1_valid_q;
	ppmfg_pkg::action_t  action_s1;
	logic [SW-1:0]       slot_s1;
	logic [VW-1:0]       nval_s1;
	logic [WW-1:0]       nfc_s1;

	// Block state.
	logic          phase_q;
	logic [SW-1:0] slot_idx_q;
	logic [WW-1:0] time_q;
	logic [WW-1:0] frames_q;
	logic [FN-1:0] done_q;

	// Next state.
	logic          phase_d;
	logic [SW-1:0] slot_idx_d;
	logic [WW-1:0] time_d;
	logic [WW-1:0] frames_d;
	logic [FN-1:0] done_d;
	logic [WW-1:0] time_base;
	logic [VW-1:0] interval;
	logic [VW-1:0] gap_raw;
	logic [VW-1:0] gap;
	logic [VW-1:0] clamped;
	logic [SW-1:0] last;
	logic          set_done;
	logic [FN-1:0] set_mask;
	logic [FN-1:0] clr_mask;
	logic          flag;
	logic [SW-1:0] rd_idx;

	// Table.
	logic          tbl_we;
	logic [VW-1:0] tbl_slot;
	logic [VW-1:0] tbl_chan;
	logic [VW-1:0] stored;

	// Output register.
	logic          m_valid_q;
	logic [VW-1:0] interval_q;
	logic          pin_q;
	logic [SW-1:0] next_slot_q;
	logic [WW-1:0] frames_out_q;
	logic [WW-1:0] elapsed_q;
	logic          flag_q;
	logic [VW-1:0] stored_q;

	ppmfg_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	always_comb begin
		if (cfg.channel_count == '0) begin
			count = SW'(1);
		end else if ({1'b0, cfg.channel_count} > (SW+1)'(MAX_CHANNELS)) begin
			count = SW'(MAX_CHANNELS);
		end else begin
			count = cfg.channel_count;
		end
	end

	assign slot_top = count - SW'(1);
	assign slot_in  = {1'b0, s_tdata[3:0]};
	assign slot_c   = (slot_in > slot_top) ? slot_top : slot_in;

	assign out_adv  = !m_valid_q || m_tready;
	assign s1_fire  = s1_valid_q && out_adv;
	assign s_tready = !s1_valid_q || out_adv;
	assign in_fire  = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_tready) begin
			s1_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			action_s1 <= ppmfg_pkg::action_t'(s_tuser);
			slot_s1   <= slot_c;
			nval_s1   <= s_tdata[19:4];
			nfc_s1    <= s_tdata[51:20];
		end
	end

	// The channel read for an edge uses the slot index as it stands after the
	// item that leaves the input stage in the same cycle.
	assign rd_idx = s1_fire ? slot_idx_d : slot_idx_q;

	always_comb begin
		if (nval_s1 < cfg.min_value) begin
			clamped = cfg.min_value;
		end else if (nval_s1 > cfg.max_value) begin
			clamped = cfg.max_value;
		end else begin
			clamped = nval_s1;
		end
	end

	assign tbl_we = s1_fire && (action_s1 == ppmfg_pkg::ACT_WRITE);

	ppmfg_table #(
		.DEPTH (MAX_CHANNELS)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.we      (tbl_we),
		.waddr   (slot_s1[IW-1:0]),
		.wdata   (clamped),
		.re      (in_fire),
		.raddr_a (slot_c[IW-1:0]),
		.raddr_b (rd_idx[IW-1:0]),
		.rd_a    (tbl_slot),
		.rd_b    (tbl_chan)
	);

	// Frame space: what is left of the period, never below the minimum gap.
	assign gap_raw = (time_q < {16'd0, cfg.frame_period})
		? (cfg.frame_period - time_q[VW-1:0]) : '0;
	assign gap = (gap_raw < cfg.min_gap) ? cfg.min_gap : gap_raw;

	always_comb begin
		phase_d    = phase_q;
		slot_idx_d = slot_idx_q;
		frames_d   = frames_q;
		time_base  = time_q;
		interval   = '0;
		last       = slot_idx_q - SW'(1);
		set_done   = 1'b0;
		unique case (action_s1)
			ppmfg_pkg::ACT_EDGE: begin
				if (!phase_q) begin
					set_done = 1'b1;
					if (slot_idx_q == '0) begin
						last      = count;
						time_base = '0;
						frames_d  = frames_q + WW'(1);
					end
					interval = cfg.spacer_width;
					phase_d  = 1'b1;
				end else begin
					if (slot_idx_q < count) begin
						interval = (tbl_chan > cfg.spacer_width)
							? (tbl_chan - cfg.spacer_width) : '0;
						slot_idx_d = slot_idx_q + SW'(1);
					end else begin
						interval   = gap;
						slot_idx_d = '0;
					end
					phase_d = 1'b0;
				end
			end
			ppmfg_pkg::ACT_SET_COUNT: frames_d = nfc_s1;
			ppmfg_pkg::ACT_WRITE, ppmfg_pkg::ACT_FLAG: ;
		endcase
	end

	assign time_d = (action_s1 == ppmfg_pkg::ACT_EDGE)
		? (time_base + {16'd0, interval}) : time_q;

	always_comb begin
		for (int i = 0; i < FN; i++) begin
			set_mask[i] = set_done && ({1'b0, last} == (SW+1)'(i));
			clr_mask[i] = (action_s1 == ppmfg_pkg::ACT_FLAG)
				&& ({1'b0, slot_s1} == (SW+1)'(i));
		end
	end

	assign flag   = |(done_q & clr_mask);
	assign done_d = (done_q | set_mask) & ~clr_mask;
	assign stored = (action_s1 == ppmfg_pkg::ACT_WRITE) ? clamped : tbl_slot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= 1'b0;
			slot_idx_q <= '0;
			time_q     <= '0;
			frames_q   <= '0;
			done_q     <= '0;
		end else if (s1_fire) begin
			phase_q    <= phase_d;
			slot_idx_q <= slot_idx_d;
			time_q     <= time_d;
			frames_q   <= frames_d;
			done_q     <= done_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_adv) begin
			m_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			interval_q   <= interval;
			pin_q        <= phase_d ^ ~cfg.inverted;
			next_slot_q  <= slot_idx_d;
			frames_out_q <= frames_d;
			elapsed_q    <= time_d;
			flag_q       <= flag;
			stored_q     <= stored;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {1'b0, stored_q, flag_q, elapsed_q, frames_out_q,
		next_slot_q, pin_q, interval_q};

endmodule

[rtl/ppmfg_ram.sv]
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ppmfg_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_a,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_b,
	output logic [WIDTH-1:0]                      rdata_a,
	output logic [WIDTH-1:0]                      rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule

[rtl/ppmfg_cfg.sv]
// Configuration register file of the frame generator.
// Depends on ppmfg_pkg for the register indexes and the settings struct.
`timescale 1ns / 1ps

module ppmfg_cfg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	output ppmfg_pkg::cfg_t     cfg
);

	ppmfg_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= ppmfg_pkg::CFG_RESET;
		end else if (cfg_valid) begin
			unique case (ppmfg_pkg::reg_idx_t'(cfg_index))
				ppmfg_pkg::REG_CHANNEL_COUNT: cfg_q.channel_count <= cfg_data[4:0];
				ppmfg_pkg::REG_FRAME_PERIOD:  cfg_q.frame_period  <= cfg_data;
				ppmfg_pkg::REG_MIN_VALUE:     cfg_q.min_value     <= cfg_data;
				ppmfg_pkg::REG_MAX_VALUE:     cfg_q.max_value     <= cfg_data;
				ppmfg_pkg::REG_MIN_GAP:       cfg_q.min_gap       <= cfg_data;
				ppmfg_pkg::REG_SPACER_WIDTH:  cfg_q.spacer_width  <= cfg_data;
				ppmfg_pkg::REG_INVERTED:      cfg_q.inverted      <= cfg_data[0];
				default: ;
			endcase
		end
	end

endmodule

[rtl/ppmfg_table.sv]
// Channel value table: RAM plus per-entry valid bits and write-to-read bypass.
// Depends on ppmfg_pkg and ppmfg_ram.
`timescale 1ns / 1ps

module ppmfg_table #(
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [ppmfg_pkg::VALUE_W-1:0]              wdata,
	input  logic                                       re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_a,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_b,
	output logic [ppmfg_pkg::VALUE_W-1:0]              rd_a,
	output logic [ppmfg_pkg::VALUE_W-1:0]              rd_b
);

	logic [ppmfg_pkg::VALUE_W-1:0] ram_a;
	logic [ppmfg_pkg::VALUE_W-1:0] ram_b;
	logic [DEPTH-1:0]              valid_q;
	logic                          vld_a_q;
	logic                          vld_b_q;
	logic                          hit_a_q;
	logic                          hit_b_q;
	logic [ppmfg_pkg::VALUE_W-1:0] wdata_q;

	ppmfg_ram #(
		.WIDTH (ppmfg_pkg::VALUE_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.re      (re),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (ram_a),
		.rdata_b (ram_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			vld_a_q <= 1'b0;
			vld_b_q <= 1'b0;
			hit_a_q <= 1'b0;
			hit_b_q <= 1'b0;
		end else begin
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			if (re) begin
				vld_a_q <= valid_q[raddr_a];
				vld_b_q <= valid_q[raddr_b];
				hit_a_q <= we && (waddr == raddr_a);
				hit_b_q <= we && (waddr == raddr_b);
			end
		end
	end

	// A write in the same cycle as the read is not yet visible in the RAM output.
	always_ff @(posedge clk) begin
		if (re) begin
			wdata_q <= wdata;
		end
	end

	assign rd_a = hit_a_q ? wdata_q : (vld_a_q ? ram_a : ppmfg_pkg::TABLE_RESET);
	assign rd_b = hit_b_q ? wdata_q : (vld_b_q ? ram_b : ppmfg_pkg::TABLE_RESET);

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for ppm_frame_generator: a directed table, then random command
// phases under several settings, checked against a local frame predictor or fixed rows.
// Depends on ppmfg_pkg and the ppm_frame_generator RTL.
`timescale 1ns / 1ps

module tb_top;

	localparam int MAX_CH       = 16;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int RANDOM_ITEMS = 900;
	localparam int PHASES       = 6;
	// Two register stages through the block, plus margin.
	localparam int DRAIN_CYCLES = 4;

	// First member sits in the highest bits, so literals read interval first.
	typedef struct packed {
		logic [15:0] interval;
		logic        pin_level;
		logic [4:0]  next_slot;
		logic [31:0] frames_sent;
		logic [31:0] elapsed;
		logic        flag;
		logic [15:0] stored_value;
	} step_result_t;

	typedef enum logic {ROW_CMD, ROW_REG} row_kind_t;

	typedef struct {
		row_kind_t           kind;
		ppmfg_pkg::action_t  act;
		ppmfg_pkg::reg_idx_t idx;
		logic [3:0]          slot;
		logic [15:0]         value;
		logic [31:0]         count;
		bit                  known;
		step_result_t        want;
	} row_t;

	logic         clk;
	logic         arst_n    = 1'b0;
	logic         s_tvalid  = 1'b0;
	logic         s_tready;
	logic [55:0]  s_tdata   = '0;
	logic [1:0]   s_tuser   = '0;
	logic         m_tvalid;
	logic         m_tready  = 1'b0;
	logic [103:0] m_tdata;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [2:0]   cfg_index = '0;
	logic [15:0]  cfg_data  = '0;

	ppm_frame_generator #(.MAX_CHANNELS(MAX_CH)) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Predictor state and its copy of the settings.
	ppmfg_pkg::cfg_t shadow_cfg = ppmfg_pkg::CFG_RESET;
	logic        st_second  = 1'b0;
	logic [4:0]  st_slot    = '0;
	logic [31:0] st_elapsed = '0;
	logic [31:0] st_frames  = '0;
	logic [16:0] st_done    = '0;
	logic [15:0] st_table [MAX_CH];

	step_result_t results_due [$];
	row_t         directed_rows [$];

	int n_errors, n_checked, n_reg_writes, n_frame_starts;
	int n_edges, n_writes, n_flags, n_loads;
	int cycle_count;
	bit tx_calm, rx_calm;
	int rx_hold, rx_mode_left = 100;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic step_result_t predict_step(ppmfg_pkg::action_t act,
			logic [3:0] slot_in, logic [15:0] nval, logic [31:0] nframes);
		step_result_t r;
		int unsigned cnt, slot, v, ivl, last;
		r   = '0;
		ivl = 0;
		cnt = 32'(shadow_cfg.channel_count);
		if (cnt < 1) cnt = 1;
		if (cnt > MAX_CH) cnt = MAX_CH;
		slot = (slot_in > cnt - 1) ? cnt - 1 : 32'(slot_in);
		case (act)
			ppmfg_pkg::ACT_EDGE: begin
				if (!st_second) begin
					// Slot 0 in the first phase opens a new frame.
					if (st_slot == 0) begin
						last       = cnt;
						st_elapsed = '0;
						st_frames  = st_frames + 32'd1;
						n_frame_starts++;
					end else begin
						last = 32'(st_slot) - 1;
					end
					st_done[last] = 1'b1;
					ivl       = 32'(shadow_cfg.spacer_width);
					st_second = 1'b1;
				end else begin
					// A slot at or past the count, also after the count shrank, is frame space.
					if (st_slot < cnt) begin
						v       = 32'(st_table[st_slot[3:0]]);
						ivl     = (v > shadow_cfg.spacer_width)
							? v - 32'(shadow_cfg.spacer_width) : 0;
						st_slot = st_slot + 5'd1;
					end else begin
						ivl = (st_elapsed < shadow_cfg.frame_period) ?
							32'(shadow_cfg.frame_period) - st_elapsed : 0;
						if (ivl < shadow_cfg.min_gap) ivl = 32'(shadow_cfg.min_gap);
						st_slot = '0;
					end
					st_second = 1'b0;
				end
				st_elapsed = st_elapsed + ivl;
			end
			ppmfg_pkg::ACT_WRITE: begin
				v = 32'(nval);
				if (v < shadow_cfg.min_value) v = 32'(shadow_cfg.min_value);
				else if (v > shadow_cfg.max_value) v = 32'(shadow_cfg.max_value);
				st_table[slot] = v[15:0];
			end
			ppmfg_pkg::ACT_FLAG: begin
				r.flag        = st_done[slot];
				st_done[slot] = 1'b0;
			end
			ppmfg_pkg::ACT_SET_COUNT: st_frames = nframes;
		endcase
		r.interval     = ivl[15:0];
		r.pin_level    = ~shadow_cfg.inverted ^ st_second;
		r.next_slot    = st_slot;
		r.frames_sent  = st_frames;
		r.elapsed      = st_elapsed;
		r.stored_value = st_table[slot];
		return r;
	endfunction

	function automatic int pick_idle(bit calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic void add_cmd(ppmfg_pkg::action_t act, logic [3:0] slot,
			logic [15:0] value, logic [31:0] count, bit known = 1'b0,
			step_result_t want = '0);
		row_t row;
		row       = '{kind: ROW_CMD, act: act, idx: ppmfg_pkg::REG_CHANNEL_COUNT, slot: slot,
			value: value, count: count, known: known, want: want};
		directed_rows.push_back(row);
	endfunction

	function automatic void add_reg(ppmfg_pkg::reg_idx_t idx, logic [15:0] value);
		row_t row;
		row = '{kind: ROW_REG, act: ppmfg_pkg::ACT_EDGE, idx: idx, slot: '0, value: value,
			count: '0, known: 1'b0, want: '0};
		directed_rows.push_back(row);
	endfunction

	task automatic note_mismatch(string what, longint unsigned got, longint unsigned want);
		$display("tb_top: mismatch in %s at result %0d: got 0x%0h, expected 0x%0h",
			what, n_checked, got, want);
		n_errors++;
	endtask

	task automatic check_result(step_result_t got);
		step_result_t want;
		if (results_due.size() == 0) begin
			note_mismatch("result with nothing outstanding", 64'(got.stored_value), 64'd0);
			return;
		end
		want = results_due.pop_front();
		if (got.interval !== want.interval)
			note_mismatch("interval", 64'(got.interval), 64'(want.interval));
		if (got.pin_level !== want.pin_level)
			note_mismatch("pin_level", 64'(got.pin_level), 64'(want.pin_level));
		if (got.next_slot !== want.next_slot)
			note_mismatch("next_slot", 64'(got.next_slot), 64'(want.next_slot));
		if (got.frames_sent !== want.frames_sent)
			note_mismatch("frames_sent", 64'(got.frames_sent), 64'(want.frames_sent));
		if (got.elapsed !== want.elapsed)
			note_mismatch("elapsed", 64'(got.elapsed), 64'(want.elapsed));
		if (got.flag !== want.flag)
			note_mismatch("flag", 64'(got.flag), 64'(want.flag));
		if (got.stored_value !== want.stored_value)
			note_mismatch("stored_value", 64'(got.stored_value), 64'(want.stored_value));
		n_checked++;
	endtask

	// Called at a rising edge; returns at the edge where the next command may be driven.
	task automatic send_command(ppmfg_pkg::action_t act, logic [3:0] slot,
			logic [15:0] value, logic [31:0] count, bit known = 1'b0,
			step_result_t want = '0);
		step_result_t predicted;
		int gap;
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {4'b0, count, value, slot};
		do @(posedge clk); while (!s_tready);
		predicted = predict_step(act, slot, value, count);
		results_due.push_back(known ? want : predicted);
		case (act)
			ppmfg_pkg::ACT_EDGE:      n_edges++;
			ppmfg_pkg::ACT_WRITE:     n_writes++;
			ppmfg_pkg::ACT_FLAG:      n_flags++;
			ppmfg_pkg::ACT_SET_COUNT: n_loads++;
		endcase
		gap = pick_idle(tx_calm);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			s_tdata  <= 56'({$urandom, $urandom});
			s_tuser  <= 2'($urandom);
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_results_drained();
		s_tvalid <= 1'b0;
		while (results_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_setting(ppmfg_pkg::reg_idx_t idx, logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			ppmfg_pkg::REG_CHANNEL_COUNT: shadow_cfg.channel_count = data[4:0];
			ppmfg_pkg::REG_FRAME_PERIOD:  shadow_cfg.frame_period  = data;
			ppmfg_pkg::REG_MIN_VALUE:     shadow_cfg.min_value     = data;
			ppmfg_pkg::REG_MAX_VALUE:     shadow_cfg.max_value     = data;
			ppmfg_pkg::REG_MIN_GAP:       shadow_cfg.min_gap       = data;
			ppmfg_pkg::REG_SPACER_WIDTH:  shadow_cfg.spacer_width  = data;
			ppmfg_pkg::REG_INVERTED:      shadow_cfg.inverted      = data[0];
			default: ;
		endcase
		n_reg_writes++;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Receive side: check every transfer and stall at random.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			check_result({m_tdata[15:0], m_tdata[16], m_tdata[21:17], m_tdata[53:22],
				m_tdata[85:54], m_tdata[86], m_tdata[102:87]});
		if (rx_hold > 0) begin
			m_tready <= 1'b0;
			rx_hold--;
		end else begin
			m_tready <= 1'b1;
			rx_hold = pick_idle(rx_calm);
		end
		rx_mode_left--;
		if (rx_mode_left <= 0) begin
			rx_calm      = ($urandom_range(0, 3) == 0);
			rx_mode_left = $urandom_range(50, 300);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_top: timeout after %0d cycles, %0d results outstanding",
				cycle_count, results_due.size());
			$display("tb_top: FAIL");
			$finish;
		end
	end

	initial begin
		int r;
		ppmfg_pkg::action_t act;
		logic [3:0] slot;
		logic [15:0] value;
		logic [31:0] count;
		for (int i = 0; i < MAX_CH; i++) st_table[i] = ppmfg_pkg::TABLE_RESET;

		// Expected columns: interval, pin, next slot, frames, elapsed, flag, stored value.
		add_cmd(ppmfg_pkg::ACT_FLAG, 4'd0, 16'd0, 32'd0, 1'b1,
			{16'd0, 1'b1, 5'd0, 32'd0, 32'd0, 1'b0, 16'd3000});
		add_cmd(ppmfg_pkg::ACT_WRITE, 4'd3, 16'd0, 32'd0, 1'b1,
			{16'd0, 1'b1, 5'd0, 32'd0, 32'd0, 1'b0, 16'd1800});
		// Slot 15 clamps to the last of the eight default channels.
		add_cmd(ppmfg_pkg::ACT_WRITE, 4'd15, 16'hFFFF, 32'd0, 1'b1,
			{16'd0, 1'b1, 5'd0, 32'd0, 32'd0, 1'b0, 16'd4200});
		add_cmd(ppmfg_pkg::ACT_EDGE, 4'd0, 16'd0, 32'd0, 1'b1,
			{16'd800, 1'b0, 5'd0, 32'd1, 32'd800, 1'b0, 16'd3000});
		add_cmd(ppmfg_pkg::ACT_EDGE, 4'd0, 16'd0, 32'd0, 1'b1,
			{16'd2200, 1'b1, 5'd1, 32'd1, 32'd3000, 1'b0, 16'd3000});
		add_cmd(ppmfg_pkg::ACT_EDGE, 4'd0, 16'd0, 32'd0, 1'b1,
			{16'd800, 1'b0, 5'd1, 32'd1, 32'd3800, 1'b0, 16'd3000});
		add_cmd(ppmfg_pkg::ACT_FLAG, 4'd0, 16'd0, 32'd0, 1'b1,
			{16'd0, 1'b0, 5'd1, 32'd1, 32'd3800, 1'b1, 16'd3000});
		add_cmd(ppmfg_pkg::ACT_FLAG, 4'd0, 16'd0, 32'd0);
		add_cmd(ppmfg_pkg::ACT_SET_COUNT, 4'd3, 16'd0, 32'hFFFF_FFFF, 1'b1,
			{16'd0, 1'b0, 5'd1, 32'hFFFF_FFFF, 32'd3800, 1'b0, 16'd1800});
		// Count drops to one while slot 1 is pending, then the frame counter wraps.
		add_reg(ppmfg_pkg::REG_CHANNEL_COUNT, 16'd0);
		add_cmd(ppmfg_pkg::ACT_EDGE, 4'd0, 16'd0, 32'd0);
		add_cmd(ppmfg_pkg::ACT_EDGE, 4'd0, 16'd0, 32'd0);
		// Spacer wider than any channel, and a frame already past its period.
		add_reg(ppmfg_pkg::REG_SPACER_WIDTH, 16'hFFFF);
		add_reg(ppmfg_pkg::REG_FRAME_PERIOD, 16'd0);
		add_reg(ppmfg_pkg::REG_MIN_GAP, 16'hFFFF);
		add_cmd(ppmfg_pkg::ACT_EDGE, 4'd0, 16'd0, 32'd0);
		add_cmd(ppmfg_pkg::ACT_EDGE, 4'd0, 16'd0, 32'd0);
		add_cmd(ppmfg_pkg::ACT_EDGE, 4'd0, 16'd0, 32'd0);
		// Count above the maximum, reversed value limits, inverted pin.
		add_reg(ppmfg_pkg::REG_CHANNEL_COUNT, 16'd31);
		add_reg(ppmfg_pkg::REG_MIN_VALUE, 16'd5000);
		add_reg(ppmfg_pkg::REG_MAX_VALUE, 16'd100);
		add_reg(ppmfg_pkg::REG_INVERTED, 16'd1);
		add_reg(ppmfg_pkg::REG_SPACER_WIDTH, 16'd0);
		add_reg(ppmfg_pkg::REG_MIN_GAP, 16'd0);
		add_reg(ppmfg_pkg::REG_FRAME_PERIOD, 16'hFFFF);
		add_cmd(ppmfg_pkg::ACT_WRITE, 4'd15, 16'd0, 32'd0);
		add_cmd(ppmfg_pkg::ACT_WRITE, 4'd14, 16'hFFFF, 32'd0);
		add_cmd(ppmfg_pkg::ACT_WRITE, 4'd13, 16'd6000, 32'd0);
		add_cmd(ppmfg_pkg::ACT_WRITE, 4'd12, 16'd3000, 32'd0);
		add_cmd(ppmfg_pkg::ACT_EDGE, 4'd15, 16'd0, 32'd0);
		add_cmd(ppmfg_pkg::ACT_EDGE, 4'd14, 16'd0, 32'd0);
		add_cmd(ppmfg_pkg::ACT_FLAG, 4'd15, 16'd0, 32'd0);
		add_cmd(ppmfg_pkg::ACT_SET_COUNT, 4'd0, 16'd0, 32'd0);
		add_cmd(ppmfg_pkg::ACT_FLAG, 4'd0, 16'd0, 32'd0);
		add_cmd(ppmfg_pkg::ACT_EDGE, 4'd0, 16'd0, 32'd0);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_REG) begin
				wait_results_drained();
				write_setting(directed_rows[i].idx, directed_rows[i].value);
			end else begin
				send_command(directed_rows[i].act, directed_rows[i].slot, directed_rows[i].value,
					directed_rows[i].count, directed_rows[i].known, directed_rows[i].want);
			end
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			wait_results_drained();
			case (phase)
				0: begin
					write_setting(ppmfg_pkg::REG_CHANNEL_COUNT,
						16'(ppmfg_pkg::CFG_RESET.channel_count));
					write_setting(ppmfg_pkg::REG_FRAME_PERIOD, ppmfg_pkg::CFG_RESET.frame_period);
					write_setting(ppmfg_pkg::REG_MIN_VALUE, ppmfg_pkg::CFG_RESET.min_value);
					write_setting(ppmfg_pkg::REG_MAX_VALUE, ppmfg_pkg::CFG_RESET.max_value);
					write_setting(ppmfg_pkg::REG_MIN_GAP, ppmfg_pkg::CFG_RESET.min_gap);
					write_setting(ppmfg_pkg::REG_SPACER_WIDTH, ppmfg_pkg::CFG_RESET.spacer_width);
					write_setting(ppmfg_pkg::REG_INVERTED, 16'(ppmfg_pkg::CFG_RESET.inverted));
				end
				1, 2: begin
					value = (phase == 1) ? 16'hFFFF : 16'h0000;
					for (int k = ppmfg_pkg::REG_CHANNEL_COUNT; k <= ppmfg_pkg::REG_INVERTED; k++)
						write_setting(ppmfg_pkg::reg_idx_t'(k), value);
				end
				default: begin
					// Mostly few channels so that frames complete often.
					write_setting(ppmfg_pkg::REG_CHANNEL_COUNT,
						($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 6)));
					write_setting(ppmfg_pkg::REG_FRAME_PERIOD, 16'($urandom));
					write_setting(ppmfg_pkg::REG_MIN_VALUE, 16'($urandom_range(0, 3000)));
					write_setting(ppmfg_pkg::REG_MAX_VALUE, 16'($urandom_range(2000, 6000)));
					write_setting(ppmfg_pkg::REG_MIN_GAP, 16'($urandom_range(0, 8000)));
					write_setting(ppmfg_pkg::REG_SPACER_WIDTH,
						($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1000)));
					write_setting(ppmfg_pkg::REG_INVERTED, 16'($urandom_range(0, 1)));
				end
			endcase
			tx_calm = ($urandom_range(0, 3) == 0);
			for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
				r = $urandom_range(0, 99);
				act = (r < 60) ? ppmfg_pkg::ACT_EDGE : (r < 80) ? ppmfg_pkg::ACT_WRITE
					: (r < 95) ? ppmfg_pkg::ACT_FLAG : ppmfg_pkg::ACT_SET_COUNT;
				slot = 4'($urandom);
				case ($urandom_range(0, 5))
					0: value = 16'($urandom_range(shadow_cfg.min_value, shadow_cfg.max_value));
					1: value = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
					2: value = shadow_cfg.spacer_width + 16'($urandom_range(0, 2)) - 16'd1;
					default: value = 16'($urandom);
				endcase
				count = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 3)
					: $urandom;
				send_command(act, slot, value, count);
				// Now and then hold off until the block has returned everything.
				if ($urandom_range(0, 99) == 0) wait_results_drained();
			end
		end

		wait_results_drained();
		$display("tb_top: %0d commands (%0d edges, %0d channel writes, %0d flag reads,",
			n_edges + n_writes + n_flags + n_loads, n_edges, n_writes, n_flags);
		$display("tb_top: %0d counter loads), %0d register writes, %0d frames started,",
			n_loads, n_reg_writes, n_frame_starts);
		$display("tb_top: %0d results checked, %0d mismatches", n_checked, n_errors);
		if (n_errors == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/ppmfg_pkg.sv
rtl/ppmfg_ram.sv
rtl/ppmfg_cfg.sv
rtl/ppmfg_table.sv
rtl/ppm_frame_generator.sv
tb/sv/tb_top.sv
